// ===== src/tpe_pkg.sv =====
// Shared types, constants and the flow-table function of the thermal plant emulator.
`timescale 1ns / 1ps
`default_nettype none
package tpe_pkg;

    // Parameter defaults
    localparam int DELAY_DEPTH_DEF     = 256;
    localparam int FLOW_EXP_MILLI_DEF  = 800;
    localparam int SENSOR_LSB_DEF      = 16;
    localparam int FLOW_TABLE_BITS_DEF = 8;

    // Configuration register indexes
    localparam logic [2:0] CFG_PWM_MIN_SPIN = 3'd0;
    localparam logic [2:0] CFG_FAN_GAIN     = 3'd1;
    localparam logic [2:0] CFG_DIE_GAIN     = 3'd2;
    localparam logic [2:0] CFG_SENSE_GAIN   = 3'd3;
    localparam logic [2:0] CFG_T_AMB        = 3'd4;
    localparam logic [2:0] CFG_RTH_MIN      = 3'd5;
    localparam logic [2:0] CFG_RTH_SPAN     = 3'd6;
    localparam logic [2:0] CFG_DELAY_STEPS  = 3'd7;

    localparam int CFG_DATA_W = 18;
    localparam int LEN_W      = 13;
    localparam int TEMP_W     = 20;
    localparam int MUL_A_W    = 28;
    localparam int MUL_B_W    = 25;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

    localparam logic [9:0]         PWM_FULL  = 10'd1000;
    localparam logic [16:0]        FAN_FULL  = 17'd65536;
    localparam logic signed [19:0] TEMP_RST  = 20'sd6400;
    localparam logic signed [19:0] TEMP_MAXV = 20'sd524287;
    localparam logic signed [19:0] TEMP_MINV = -20'sd524288;
    // floor(2^36 / 1000), used to turn PWM tenths into a Q0.16 command
    localparam logic [26:0]        PWM_RECIP = 27'd68719476;
    localparam int                 PWM_SHIFT = 36;

    // Reset values of the registers
    localparam logic [9:0]         RST_PWM_MIN_SPIN = 10'd200;
    localparam logic [15:0]        RST_FAN_GAIN     = 16'd655;
    localparam logic [15:0]        RST_DIE_GAIN     = 16'd65;
    localparam logic [15:0]        RST_SENSE_GAIN   = 16'd655;
    localparam logic signed [17:0] RST_T_AMB        = 18'sd6400;
    localparam logic [15:0]        RST_RTH_MIN      = 16'd410;
    localparam logic [15:0]        RST_RTH_SPAN     = 16'd4096;
    localparam logic [8:0]         RST_DELAY_STEPS  = 9'd10;

    typedef struct packed {
        logic [9:0]         pwm_min_spin;
        logic [15:0]        fan_gain;
        logic [15:0]        die_gain;
        logic [15:0]        sense_gain;
        logic signed [17:0] t_amb;
        logic [15:0]        rth_min;
        logic [15:0]        rth_span;
        logic [8:0]         delay_steps;
    } t_cfg;

    typedef struct packed {
        logic [16:0] cmd;
        logic [15:0] power;
    } t_item;

    function automatic longint unsigned isqrt64(input longint unsigned v);
        longint unsigned x;
        longint unsigned r;
        longint unsigned b;
        x = v;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 64'd0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Entry i of the flow table: 65536 * (1 - (i / 2^tb)^(em / 1000)), integer log and exp.
    function automatic logic [16:0] flow_entry(input int i, input int tb, input int em);
        longint unsigned c [31];
        longint unsigned y;
        longint unsigned frac;
        longint unsigned mag;
        longint unsigned k;
        longint unsigned f;
        longint unsigned r;
        longint          lg;
        int              msb;
        int              j;
        if (i == 0) return 17'd65536;
        c[0] = 64'd0;
        c[1] = isqrt64(64'd1 << 63);
        for (j = 2; j <= 30; j++) c[j] = isqrt64(c[j - 1] << 32);
        msb = 0;
        while ((i >> (msb + 1)) != 0) msb++;
        y = (longint'(i) << 31) >> msb;
        frac = 64'd0;
        for (j = 0; j < 30; j++) begin
            y = (y * y) >> 31;
            frac = frac << 1;
            if (y >= (64'd2 << 31)) begin
                frac = frac | 64'd1;
                y = y >> 1;
            end
        end
        lg = longint'((longint'(msb) << 30) | frac) - (longint'(tb) << 30);
        mag = longint'(-lg) * longint'(em) / 1000;
        k = mag >> 30;
        f = mag & ((64'd1 << 30) - 64'd1);
        r = 64'd1 << 32;
        for (j = 1; j <= 30; j++) begin
            if (((f >> (30 - j)) & 64'd1) != 64'd0) r = (r * c[j]) >> 32;
        end
        r = (k >= 64'd34) ? 64'd0 : (r >> k);
        r = (r + 64'd32768) >> 16;
        if (r > 64'd65536) r = 64'd65536;
        return 17'(64'd65536 - r);
    endfunction

endpackage
`default_nettype wire

// ===== src/tpe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tpe_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== src/tpe_front.sv =====
// Front end: accepts ticks, clamps PWM and turns it into a Q0.16 fan command.
`timescale 1ns / 1ps
`default_nettype none
module tpe_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_enable,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [9:0]    i_pwm,
    input  wire logic [15:0]   i_power,
    input  wire logic [9:0]    i_min_spin,
    input  wire logic          i_q_full,
    output logic               o_q_push,
    output tpe_pkg::t_item     o_q_item
);
    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_FIX, ST_PUSH} t_state;

    t_state       r_state, n_state;
    logic [9:0]   r_pwm, n_pwm;
    logic         r_zero, n_zero;
    logic [15:0]  r_power, n_power;
    logic [16:0]  r_q0, n_q0;
    logic [16:0]  r_cmd, n_cmd;

    logic [9:0]   w_pwm_clamp;
    logic [25:0]  w_x;
    logic [52:0]  w_prod;
    logic [26:0]  w_p;
    logic [26:0]  w_rem;
    logic         w_accept;

    assign o_ready  = (r_state == ST_IDLE) && i_enable;
    assign w_accept = i_valid && o_ready;
    assign w_pwm_clamp = (i_pwm > tpe_pkg::PWM_FULL) ? tpe_pkg::PWM_FULL : i_pwm;
    // x = pwm * 65536 + 500, so that x / 1000 rounds the command to nearest
    assign w_x    = {r_pwm, 16'd0} + 26'd500;
    assign w_prod = 53'(w_x) * 53'(tpe_pkg::PWM_RECIP);
    assign w_p    = 27'(r_q0) * 27'd1000;
    assign w_rem  = 27'(w_x) - w_p;

    assign o_q_push       = (r_state == ST_PUSH) && !i_q_full;
    assign o_q_item.cmd   = r_cmd;
    assign o_q_item.power = r_power;

    always_comb begin
        n_state = r_state;
        n_pwm   = r_pwm;
        n_zero  = r_zero;
        n_power = r_power;
        n_q0    = r_q0;
        n_cmd   = r_cmd;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_pwm   = w_pwm_clamp;
                    n_zero  = w_pwm_clamp < i_min_spin;
                    n_power = i_power;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_q0    = w_prod[52:tpe_pkg::PWM_SHIFT];
                n_state = ST_FIX;
            end
            ST_FIX: begin
                // The reciprocal estimate is at most one short of the quotient.
                if (r_zero) begin
                    n_cmd = 17'd0;
                end else if (w_rem >= 27'd1000) begin
                    n_cmd = r_q0 + 17'd1;
                end else begin
                    n_cmd = r_q0;
                end
                n_state = ST_PUSH;
            end
            ST_PUSH: begin
                if (!i_q_full) n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_pwm   <= n_pwm;
        r_zero  <= n_zero;
        r_power <= n_power;
        r_q0    <= n_q0;
        r_cmd   <= n_cmd;
    end
endmodule
`default_nettype wire

// ===== src/tpe_queue.sv =====
// Two-entry queue between the front end and the plant datapath.
`timescale 1ns / 1ps
`default_nettype none
module tpe_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  tpe_pkg::t_item      i_item,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output tpe_pkg::t_item      o_item
);
    tpe_pkg::t_item r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_item;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("queue read while empty");
endmodule
`default_nettype wire

// ===== src/tpe_back.sv =====
// Plant datapath: fan lag, thermal resistance, die lag, dead time, sensor lag, outputs.
`timescale 1ns / 1ps
`default_nettype none
module tpe_back #(
    parameter int DELAY_DEPTH     = tpe_pkg::DELAY_DEPTH_DEF,
    parameter int FLOW_EXP_MILLI  = tpe_pkg::FLOW_EXP_MILLI_DEF,
    parameter int SENSOR_LSB      = tpe_pkg::SENSOR_LSB_DEF,
    parameter int FLOW_TABLE_BITS = tpe_pkg::FLOW_TABLE_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  tpe_pkg::t_cfg       i_cfg,
    input  wire logic           i_q_valid,
    input  tpe_pkg::t_item      i_q_item,
    output logic                o_q_pop,
    output logic                o_init_done,
    output logic                o_m_valid,
    input  wire logic           i_m_ready,
    output logic signed [17:0]  o_sensed_temp,
    output logic [16:0]         o_fan_power_rel
);
    localparam int AW       = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int TB       = FLOW_TABLE_BITS;
    localparam int ROM_SIZE = (1 << TB) + 1;
    localparam int RECIP    = (1 << 24) / SENSOR_LSB;
    localparam int IDX_HALF = 1 << (15 - TB);

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_FAN, ST_FUPD, ST_SPAN, ST_PWR, ST_TSS, ST_DIE,
        ST_DUPD, ST_SNS, ST_SUPD, ST_RND, ST_RQ, ST_RFIX, ST_Q2, ST_Q3
    } t_state;

    t_state                        r_state, n_state;
    logic [AW-1:0]                 r_clr, n_clr;
    logic [AW-1:0]                 r_ptr, n_ptr;
    logic [16:0]                   r_cmd, n_cmd;
    logic [15:0]                   r_power, n_power;
    logic [16:0]                   r_fan, n_fan;
    logic signed [19:0]            r_die, n_die;
    logic signed [19:0]            r_sense, n_sense;
    logic signed [26:0]            r_tss, n_tss;
    logic                          r_neg, n_neg;
    logic [tpe_pkg::MUL_P_W-1:0]   r_prod, n_prod;
    logic signed [17:0]            r_temp_hold, n_temp_hold;
    logic                          r_out_valid, n_out_valid;
    logic signed [17:0]            r_out_temp, n_out_temp;
    logic [16:0]                   r_out_fan, n_out_fan;

    logic [tpe_pkg::MUL_A_W-1:0]   w_mul_a;
    logic [tpe_pkg::MUL_B_W-1:0]   w_mul_b;
    logic [tpe_pkg::MUL_P_W-1:0]   w_rnd16;
    logic [tpe_pkg::MUL_P_W-1:0]   w_rnd8;
    logic signed [29:0]            w_step;
    logic signed [29:0]            w_fan_sum;
    logic signed [29:0]            w_die_sum;
    logic signed [29:0]            w_sns_sum;
    logic signed [17:0]            w_fan_diff;
    logic signed [27:0]            w_die_diff;
    logic signed [20:0]            w_sns_diff;
    logic [16:0]                   w_idx_full;
    logic [TB:0]                   w_idx;
    logic [16:0]                   w_rom [ROM_SIZE];
    logic [16:0]                   w_rth;
    logic [tpe_pkg::LEN_W-1:0]     w_len;
    logic [AW-1:0]                 w_ptr_eff;
    logic [AW-1:0]                 w_ptr_next;
    logic [19:0]                   w_s_mag;
    logic [20:0]                   w_x;
    logic [21:0]                   w_p;
    logic [21:0]                   w_rem;
    logic [21:0]                   w_rmag;
    logic signed [19:0]            w_arrived;
    logic                          w_ram_we;
    logic [AW-1:0]                 w_ram_waddr;
    logic signed [19:0]            w_ram_wdata;
    logic                          w_ram_re;
    logic                          w_out_free;

    for (genvar g = 0; g < ROM_SIZE; g++) begin : g_rom
        assign w_rom[g] = tpe_pkg::flow_entry(g, FLOW_TABLE_BITS, FLOW_EXP_MILLI);
    end

    tpe_ram #(
        .WIDTH (tpe_pkg::TEMP_W),
        .DEPTH (DELAY_DEPTH),
        .AW    (AW)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ptr_eff),
        .o_rdata (w_arrived)
    );

    assign o_init_done     = r_state != ST_CLR;
    assign o_q_pop         = (r_state == ST_IDLE) && i_q_valid;
    assign o_m_valid       = r_out_valid;
    assign o_sensed_temp   = r_out_temp;
    assign o_fan_power_rel = r_out_fan;
    assign w_out_free      = !r_out_valid || i_m_ready;

    // Every lag rounds half away from zero on the magnitude.
    assign w_rnd16 = (r_prod + tpe_pkg::MUL_P_W'(32768)) >> 16;
    assign w_rnd8  = (r_prod + tpe_pkg::MUL_P_W'(128)) >> 8;
    assign w_step  = r_neg ? -$signed({1'b0, w_rnd16[28:0]}) : $signed({1'b0, w_rnd16[28:0]});
    assign w_fan_sum = $signed({13'd0, r_fan}) + w_step;
    assign w_die_sum = 30'(r_die) + w_step;
    assign w_sns_sum = 30'(r_sense) + w_step;

    assign w_fan_diff = $signed({1'b0, r_cmd}) - $signed({1'b0, r_fan});
    assign w_die_diff = 28'(r_tss) - 28'(r_die);
    assign w_sns_diff = 21'(w_arrived) - 21'(r_sense);

    assign w_idx_full = (r_fan + 17'(IDX_HALF)) >> (16 - TB);
    assign w_idx = (w_idx_full > 17'(ROM_SIZE - 1)) ? (TB + 1)'(ROM_SIZE - 1)
                                                     : w_idx_full[TB:0];
    assign w_rth = 17'(i_cfg.rth_min) + w_rnd16[16:0];

    assign w_len = (i_cfg.delay_steps == 9'd0) ? tpe_pkg::LEN_W'(1) :
                   (tpe_pkg::LEN_W'(i_cfg.delay_steps) > tpe_pkg::LEN_W'(DELAY_DEPTH))
                       ? tpe_pkg::LEN_W'(DELAY_DEPTH) : tpe_pkg::LEN_W'(i_cfg.delay_steps);
    assign w_ptr_eff  = (tpe_pkg::LEN_W'(r_ptr) >= w_len) ? AW'(0) : r_ptr;
    assign w_ptr_next = (tpe_pkg::LEN_W'(r_ptr) + tpe_pkg::LEN_W'(1) >= w_len)
                        ? AW'(0) : AW'(tpe_pkg::LEN_W'(r_ptr) + tpe_pkg::LEN_W'(1));

    assign w_s_mag = r_sense[19] ? 20'(-r_sense) : 20'(r_sense);
    assign w_x     = {1'b0, w_s_mag} + 21'(SENSOR_LSB / 2);
    assign w_p     = r_prod[21:0];
    assign w_rem   = 22'(w_x) - w_p;
    assign w_rmag  = (w_rem >= 22'(SENSOR_LSB)) ? w_p + 22'(SENSOR_LSB) : w_p;

    assign w_ram_re = r_state == ST_FAN;

    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = r_ptr;
        w_ram_wdata = n_die;
        if (r_state == ST_CLR) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = r_clr;
            w_ram_wdata = tpe_pkg::TEMP_RST;
        end else if (r_state == ST_DUPD) begin
            w_ram_we = 1'b1;
        end
    end

    // One shared multiplier; its operands follow the step in hand.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            ST_FAN: begin
                w_mul_a = w_fan_diff[17] ? tpe_pkg::MUL_A_W'(-w_fan_diff)
                                         : tpe_pkg::MUL_A_W'(w_fan_diff);
                w_mul_b = tpe_pkg::MUL_B_W'(i_cfg.fan_gain);
            end
            ST_SPAN: begin
                w_mul_a = tpe_pkg::MUL_A_W'(w_rom[w_idx]);
                w_mul_b = tpe_pkg::MUL_B_W'(i_cfg.rth_span);
            end
            ST_PWR: begin
                w_mul_a = tpe_pkg::MUL_A_W'(r_power);
                w_mul_b = tpe_pkg::MUL_B_W'(w_rth);
            end
            ST_DIE: begin
                w_mul_a = w_die_diff[27] ? tpe_pkg::MUL_A_W'(-w_die_diff)
                                         : tpe_pkg::MUL_A_W'(w_die_diff);
                w_mul_b = tpe_pkg::MUL_B_W'(i_cfg.die_gain);
            end
            ST_SNS: begin
                w_mul_a = w_sns_diff[20] ? tpe_pkg::MUL_A_W'(-w_sns_diff)
                                         : tpe_pkg::MUL_A_W'(w_sns_diff);
                w_mul_b = tpe_pkg::MUL_B_W'(i_cfg.sense_gain);
            end
            ST_RND: begin
                w_mul_a = tpe_pkg::MUL_A_W'(w_x);
                w_mul_b = tpe_pkg::MUL_B_W'(RECIP);
            end
            ST_RQ: begin
                w_mul_a = tpe_pkg::MUL_A_W'(r_prod[44:24]);
                w_mul_b = tpe_pkg::MUL_B_W'(SENSOR_LSB);
            end
            ST_RFIX: begin
                w_mul_a = tpe_pkg::MUL_A_W'(r_fan);
                w_mul_b = tpe_pkg::MUL_B_W'(r_fan);
            end
            ST_Q2: begin
                w_mul_a = tpe_pkg::MUL_A_W'(w_rnd16[16:0]);
                w_mul_b = tpe_pkg::MUL_B_W'(r_fan);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_ptr       = r_ptr;
        n_cmd       = r_cmd;
        n_power     = r_power;
        n_fan       = r_fan;
        n_die       = r_die;
        n_sense     = r_sense;
        n_tss       = r_tss;
        n_neg       = r_neg;
        n_prod      = (r_state == ST_Q3) ? r_prod : 53'(w_mul_a) * 53'(w_mul_b);
        n_temp_hold = r_temp_hold;
        n_out_valid = r_out_valid && !i_m_ready;
        n_out_temp  = r_out_temp;
        n_out_fan   = r_out_fan;
        unique case (r_state)
            ST_CLR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(DELAY_DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_cmd   = i_q_item.cmd;
                    n_power = i_q_item.power;
                    n_state = ST_FAN;
                end
            end
            ST_FAN: begin
                n_neg   = w_fan_diff[17];
                n_ptr   = w_ptr_eff;
                n_state = ST_FUPD;
            end
            ST_FUPD: begin
                if (w_fan_sum < 30'sd0) begin
                    n_fan = 17'd0;
                end else if (w_fan_sum > $signed({13'd0, tpe_pkg::FAN_FULL})) begin
                    n_fan = tpe_pkg::FAN_FULL;
                end else begin
                    n_fan = w_fan_sum[16:0];
                end
                n_state = ST_SPAN;
            end
            ST_SPAN: n_state = ST_PWR;
            ST_PWR:  n_state = ST_TSS;
            ST_TSS: begin
                n_tss   = 27'(i_cfg.t_amb) + $signed({2'b0, w_rnd8[24:0]});
                n_state = ST_DIE;
            end
            ST_DIE: begin
                n_neg   = w_die_diff[27];
                n_state = ST_DUPD;
            end
            ST_DUPD: begin
                if (w_die_sum > 30'(tpe_pkg::TEMP_MAXV)) begin
                    n_die = tpe_pkg::TEMP_MAXV;
                end else if (w_die_sum < 30'(tpe_pkg::TEMP_MINV)) begin
                    n_die = tpe_pkg::TEMP_MINV;
                end else begin
                    n_die = w_die_sum[19:0];
                end
                n_ptr   = w_ptr_next;
                n_state = ST_SNS;
            end
            ST_SNS: begin
                n_neg   = w_sns_diff[20];
                n_state = ST_SUPD;
            end
            ST_SUPD: begin
                if (w_sns_sum > 30'(tpe_pkg::TEMP_MAXV)) begin
                    n_sense = tpe_pkg::TEMP_MAXV;
                end else if (w_sns_sum < 30'(tpe_pkg::TEMP_MINV)) begin
                    n_sense = tpe_pkg::TEMP_MINV;
                end else begin
                    n_sense = w_sns_sum[19:0];
                end
                n_state = ST_RND;
            end
            ST_RND: n_state = ST_RQ;
            ST_RQ:  n_state = ST_RFIX;
            ST_RFIX: begin
                // The reading saturates to the 18-bit output range after rounding.
                // It is held aside so that a result still waiting at the output stays intact.
                if (r_sense[19]) begin
                    n_temp_hold = (w_rmag > 22'd131072) ? -18'sd131072 : 18'(-w_rmag);
                end else begin
                    n_temp_hold = (w_rmag > 22'd131071) ? 18'sd131071 : 18'(w_rmag);
                end
                n_state = ST_Q2;
            end
            ST_Q2: n_state = ST_Q3;
            ST_Q3: begin
                if (w_out_free) begin
                    n_out_temp  = r_temp_hold;
                    n_out_fan   = w_rnd16[16:0];
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr       <= '0;
            r_ptr       <= '0;
            r_fan       <= '0;
            r_die       <= tpe_pkg::TEMP_RST;
            r_sense     <= tpe_pkg::TEMP_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_ptr       <= n_ptr;
            r_fan       <= n_fan;
            r_die       <= n_die;
            r_sense     <= n_sense;
            r_out_valid <= n_out_valid;
        end
        r_cmd       <= n_cmd;
        r_power     <= n_power;
        r_tss       <= n_tss;
        r_neg       <= n_neg;
        r_prod      <= n_prod;
        r_temp_hold <= n_temp_hold;
        r_out_temp  <= n_out_temp;
        r_out_fan   <= n_out_fan;
    end

    a_fan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fan <= tpe_pkg::FAN_FULL)
        else $error("fan speed above full scale");
    a_ptr_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUPD) |-> (tpe_pkg::LEN_W'(r_ptr) < w_len))
        else $error("delay line pointer beyond its length");
    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLR) |-> !o_q_pop)
        else $error("item taken during the clearing pass");
endmodule
`default_nettype wire

// ===== src/thermal_plant_emulator_step.sv =====
// Top level of the thermal plant emulator: configuration registers, front end, queue, datapath.
//
//  Channel   Direction  Transfer when                  Contents
//  s_axis    in         s_axis_tvalid & s_axis_tready  one plant tick (PWM, power)
//  m_axis    out        m_axis_tvalid & m_axis_tready  sensor reading, relative fan power
//  cfg       in         i_cfg_valid & o_cfg_ready      register index and value
//
// Each tick passes the front end and then the datapath's steps around its
// single shared multiplier; the front end overlaps these with the next tick.
// After reset all DELAY_DEPTH entries of the delay line are cleared; s_axis_tready stays low until then.
// A waiting result is held in the output register while the next tick is processed.
`timescale 1ns / 1ps
`default_nettype none
module thermal_plant_emulator_step #(
    parameter int DELAY_DEPTH     = tpe_pkg::DELAY_DEPTH_DEF,
    parameter int FLOW_EXP_MILLI  = tpe_pkg::FLOW_EXP_MILLI_DEF,
    parameter int SENSOR_LSB      = tpe_pkg::SENSOR_LSB_DEF,
    parameter int FLOW_TABLE_BITS = tpe_pkg::FLOW_TABLE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // pwm_tenths[9:0], power_in[25:10], zeros
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // sensed_temp[17:0], fan_power_rel[34:18], zeros
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [tpe_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    tpe_pkg::t_cfg      r_cfg;
    tpe_pkg::t_item     w_push_item;
    tpe_pkg::t_item     w_pop_item;
    logic               w_push;
    logic               w_full;
    logic               w_pop;
    logic               w_q_valid;
    logic               w_init_done;
    logic signed [17:0] w_sensed_temp;
    logic [16:0]        w_fan_power_rel;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {5'd0, w_fan_power_rel, w_sensed_temp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pwm_min_spin <= tpe_pkg::RST_PWM_MIN_SPIN;
            r_cfg.fan_gain     <= tpe_pkg::RST_FAN_GAIN;
            r_cfg.die_gain     <= tpe_pkg::RST_DIE_GAIN;
            r_cfg.sense_gain   <= tpe_pkg::RST_SENSE_GAIN;
            r_cfg.t_amb        <= tpe_pkg::RST_T_AMB;
            r_cfg.rth_min      <= tpe_pkg::RST_RTH_MIN;
            r_cfg.rth_span     <= tpe_pkg::RST_RTH_SPAN;
            r_cfg.delay_steps  <= tpe_pkg::RST_DELAY_STEPS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tpe_pkg::CFG_PWM_MIN_SPIN: r_cfg.pwm_min_spin <= i_cfg_data[9:0];
                tpe_pkg::CFG_FAN_GAIN:     r_cfg.fan_gain     <= i_cfg_data[15:0];
                tpe_pkg::CFG_DIE_GAIN:     r_cfg.die_gain     <= i_cfg_data[15:0];
                tpe_pkg::CFG_SENSE_GAIN:   r_cfg.sense_gain   <= i_cfg_data[15:0];
                tpe_pkg::CFG_T_AMB:        r_cfg.t_amb        <= $signed(i_cfg_data[17:0]);
                tpe_pkg::CFG_RTH_MIN:      r_cfg.rth_min      <= i_cfg_data[15:0];
                tpe_pkg::CFG_RTH_SPAN:     r_cfg.rth_span     <= i_cfg_data[15:0];
                tpe_pkg::CFG_DELAY_STEPS:  r_cfg.delay_steps  <= i_cfg_data[8:0];
            endcase
        end
    end

    tpe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_enable   (w_init_done),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_pwm      (s_axis_tdata[9:0]),
        .i_power    (s_axis_tdata[25:10]),
        .i_min_spin (r_cfg.pwm_min_spin),
        .i_q_full   (w_full),
        .o_q_push   (w_push),
        .o_q_item   (w_push_item)
    );

    tpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_pop_item)
    );

    tpe_back #(
        .DELAY_DEPTH     (DELAY_DEPTH),
        .FLOW_EXP_MILLI  (FLOW_EXP_MILLI),
        .SENSOR_LSB      (SENSOR_LSB),
        .FLOW_TABLE_BITS (FLOW_TABLE_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_valid       (w_q_valid),
        .i_q_item        (w_pop_item),
        .o_q_pop         (w_pop),
        .o_init_done     (w_init_done),
        .o_m_valid       (m_axis_tvalid),
        .i_m_ready       (m_axis_tready),
        .o_sensed_temp   (w_sensed_temp),
        .o_fan_power_rel (w_fan_power_rel)
    );
endmodule
`default_nettype wire

// ===== sim/tpe_checker.sv =====
// Checker for the thermal plant emulator: watches the channels, predicts and compares results.
`timescale 1ns / 1ps
module tpe_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [39:0] m_axis_tdata,
    input  wire logic        i_cfg_valid,
    input  wire logic        o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [17:0] i_cfg_data,
    output int               o_errors,
    output int               o_pending
);
    localparam int DEPTH = tpe_pkg::DELAY_DEPTH_DEF;
    localparam int LSB   = tpe_pkg::SENSOR_LSB_DEF;
    localparam int TBITS = tpe_pkg::FLOW_TABLE_BITS_DEF;
    localparam int EXPM  = tpe_pkg::FLOW_EXP_MILLI_DEF;

    longint      pwm_min_spin, fan_gain, die_gain, sense_gain, t_amb;
    longint      rth_min, rth_span, delay_steps;
    longint      fan_speed, die_temp, sense_temp;
    longint      dead_line [DEPTH];
    longint      line_ptr;
    longint      flow_rom [(1 << TBITS) + 1];
    logic [34:0] expected_readings [$];

    assign o_pending = expected_readings.size();

    // Integer square root, used to build the exp2 constants of the flow table.
    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic build_flow_table();
        longint unsigned c [31];
        longint unsigned y, frac, mag, k, f, r;
        longint          lg;
        int              msb;
        c[0] = 0;
        c[1] = root64(64'd1 << 63);
        for (int j = 2; j <= 30; j++) c[j] = root64(c[j - 1] << 32);
        flow_rom[0] = 65536;
        for (int i = 1; i <= (1 << TBITS); i++) begin
            msb = 0;
            while ((i >> (msb + 1)) != 0) msb++;
            y = (64'(i) << 31) >> msb;
            frac = 0;
            for (int j = 0; j < 30; j++) begin
                y = (y * y) >> 31;
                frac = frac << 1;
                if (y >= (64'd2 << 31)) begin
                    frac = frac | 1;
                    y = y >> 1;
                end
            end
            lg = longint'((64'(msb) << 30) | frac) - (longint'(TBITS) << 30);
            mag = longint'(-lg) * EXPM / 1000;
            k = mag >> 30;
            f = mag & ((64'd1 << 30) - 1);
            r = 64'd1 << 32;
            for (int j = 1; j <= 30; j++)
                if (((f >> (30 - j)) & 1) != 0) r = (r * c[j]) >> 32;
            r = (k >= 34) ? 0 : (r >> k);
            r = (r + 32768) >> 16;
            if (r > 65536) r = 65536;
            flow_rom[i] = 65536 - longint'(r);
        end
    endtask

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint lag_step(input longint diff, input longint gain);
        longint m;
        m = diff < 0 ? -diff : diff;
        m = (m * gain + 32768) >>> 16;
        return diff < 0 ? -m : m;
    endfunction

    task automatic plant_tick(input logic [9:0] pwm_in, input logic [15:0] power);
        longint pwm, cmd, q, idx, rth, tss, arrived, mag, rounded, q2, q3, len;
        pwm = pwm_in;
        if (pwm > 1000) pwm = 1000;
        cmd = pwm < pwm_min_spin ? 0 : (pwm * 65536 + 500) / 1000;
        fan_speed = clip(fan_speed + lag_step(cmd - fan_speed, fan_gain), 0, 65536);
        q = fan_speed;
        idx = (q * (1 << TBITS) + 32768) >>> 16;
        if (idx > (1 << TBITS)) idx = 1 << TBITS;
        rth = rth_min + ((rth_span * flow_rom[idx] + 32768) >>> 16);
        tss = t_amb + ((longint'(power) * rth + 128) >>> 8);
        die_temp = clip(die_temp + lag_step(tss - die_temp, die_gain), -524288, 524287);
        len = delay_steps == 0 ? 1 : delay_steps;
        if (len > DEPTH) len = DEPTH;
        if (line_ptr >= len) line_ptr = 0;
        arrived = dead_line[line_ptr];
        dead_line[line_ptr] = die_temp;
        line_ptr = line_ptr + 1 >= len ? 0 : line_ptr + 1;
        sense_temp = clip(sense_temp + lag_step(arrived - sense_temp, sense_gain),
                          -524288, 524287);
        mag = sense_temp < 0 ? -sense_temp : sense_temp;
        mag = ((mag + LSB / 2) / LSB) * LSB;
        rounded = clip(sense_temp < 0 ? -mag : mag, -131072, 131071);
        q2 = (q * q + 32768) >>> 16;
        q3 = (q2 * q + 32768) >>> 16;
        expected_readings.insert(expected_readings.size(), {17'(q3), 18'(rounded)});
    endtask

    initial begin
        o_errors = 0;
        build_flow_table();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pwm_min_spin = tpe_pkg::RST_PWM_MIN_SPIN;
            fan_gain     = tpe_pkg::RST_FAN_GAIN;
            die_gain     = tpe_pkg::RST_DIE_GAIN;
            sense_gain   = tpe_pkg::RST_SENSE_GAIN;
            t_amb        = tpe_pkg::RST_T_AMB;
            rth_min      = tpe_pkg::RST_RTH_MIN;
            rth_span     = tpe_pkg::RST_RTH_SPAN;
            delay_steps  = tpe_pkg::RST_DELAY_STEPS;
            fan_speed    = 0;
            die_temp     = 6400;
            sense_temp   = 6400;
            line_ptr     = 0;
            for (int k = 0; k < DEPTH; k++) dead_line[k] = 6400;
            expected_readings.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    tpe_pkg::CFG_PWM_MIN_SPIN: pwm_min_spin = i_cfg_data[9:0];
                    tpe_pkg::CFG_FAN_GAIN:     fan_gain     = i_cfg_data[15:0];
                    tpe_pkg::CFG_DIE_GAIN:     die_gain     = i_cfg_data[15:0];
                    tpe_pkg::CFG_SENSE_GAIN:   sense_gain   = i_cfg_data[15:0];
                    tpe_pkg::CFG_T_AMB:        t_amb        = longint'($signed(i_cfg_data));
                    tpe_pkg::CFG_RTH_MIN:      rth_min      = i_cfg_data[15:0];
                    tpe_pkg::CFG_RTH_SPAN:     rth_span     = i_cfg_data[15:0];
                    tpe_pkg::CFG_DELAY_STEPS:  delay_steps  = i_cfg_data[8:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                plant_tick(s_axis_tdata[9:0], s_axis_tdata[25:10]);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_readings.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_axis_tdata);
                    o_errors = o_errors + 1;
                end else if (expected_readings[0][17:0] !== m_axis_tdata[17:0] ||
                             expected_readings[0][34:18] !== m_axis_tdata[34:18]) begin
                    $display("%0t: mismatch temp exp %0d got %0d, fan exp %0d got %0d",
                             $time, $signed(expected_readings[0][17:0]),
                             $signed(m_axis_tdata[17:0]), expected_readings[0][34:18],
                             m_axis_tdata[34:18]);
                    o_errors = o_errors + 1;
                    expected_readings.delete(0);
                end else begin
                    expected_readings.delete(0);
                end
            end
        end
    end
endmodule

// ===== sim/tb.sv =====
// Top of the thermal plant emulator testbench: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module tb;
    localparam int STALL_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [17:0] i_cfg_data = '0;
    int          errors;
    int          pending;
    int          idle_cycles = 0;
    bit          rx_stall_on = 1'b1;

    always #1 i_clk = ~i_clk;

    thermal_plant_emulator_step DUT (.*);

    tpe_checker u_checker (.*, .o_errors(errors), .o_pending(pending));

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    // Receiver side: random stalls, switched off during one of the random phases.
    always @(posedge i_clk) begin
        if (!rx_stall_on) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
    end

    // Watchdog on cycles with no transaction on any channel.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Valid stays high after the transaction; a gap or a drain drops it.
    task automatic send_tick(input logic [9:0] pwm, input logic [15:0] power, input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, power, pwm};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [17:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits for every result, then for the block's own latency to run out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic random_ticks(input int n);
        logic [9:0] pwm;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: pwm = 10'($urandom_range(0, 1023));
                1: pwm = 10'($urandom_range(980, 1023));
                default: pwm = 10'($urandom_range(150, 1000));
            endcase
            send_tick(pwm, 16'($urandom), i % 97 > 20);
        end
    endtask

    task automatic random_config();
        write_reg(tpe_pkg::CFG_PWM_MIN_SPIN, 18'($urandom_range(0, 1023)));
        write_reg(tpe_pkg::CFG_FAN_GAIN, 18'($urandom_range(0, 65535)));
        write_reg(tpe_pkg::CFG_DIE_GAIN, 18'($urandom_range(0, 65535)));
        write_reg(tpe_pkg::CFG_SENSE_GAIN, 18'($urandom_range(0, 65535)));
        write_reg(tpe_pkg::CFG_T_AMB, 18'($urandom));
        write_reg(tpe_pkg::CFG_RTH_MIN, 18'($urandom_range(0, 65535)));
        write_reg(tpe_pkg::CFG_RTH_SPAN, 18'($urandom_range(0, 65535)));
        write_reg(tpe_pkg::CFG_DELAY_STEPS, 18'($urandom_range(0, 511)));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes of PWM and power at reset settings.
        send_tick(10'd0, 16'd0, 0);
        send_tick(10'd1023, 16'hFFFF, 0);
        send_tick(10'd1000, 16'hFFFF, 0);
        send_tick(10'd1001, 16'd0, 0);
        send_tick(10'd199, 16'h5555, 0);
        send_tick(10'd200, 16'hAAAA, 0);
        send_tick(10'h155, 16'h8000, 0);
        send_tick(10'h2AA, 16'h7FFF, 0);
        drain();

        // Spin threshold above full scale, zero delay, maximum gains, ambient and thermal resistance.
        write_reg(tpe_pkg::CFG_PWM_MIN_SPIN, 18'd1023);
        write_reg(tpe_pkg::CFG_DELAY_STEPS, 18'd0);
        write_reg(tpe_pkg::CFG_FAN_GAIN, 18'd65535);
        write_reg(tpe_pkg::CFG_DIE_GAIN, 18'd65535);
        write_reg(tpe_pkg::CFG_SENSE_GAIN, 18'd65535);
        write_reg(tpe_pkg::CFG_T_AMB, 18'h1FFFF);
        write_reg(tpe_pkg::CFG_RTH_MIN, 18'd65535);
        write_reg(tpe_pkg::CFG_RTH_SPAN, 18'd65535);
        for (int i = 0; i < 4; i++) send_tick(10'd1000, 16'hFFFF, 0);
        drain();
        write_reg(tpe_pkg::CFG_PWM_MIN_SPIN, 18'd0);
        write_reg(tpe_pkg::CFG_T_AMB, 18'h20000);
        write_reg(tpe_pkg::CFG_DELAY_STEPS, 18'd511);
        for (int i = 0; i < 4; i++) send_tick(10'd0, 16'd0, 0);
        drain();
        write_reg(tpe_pkg::CFG_DELAY_STEPS, 18'd3);
        write_reg(tpe_pkg::CFG_FAN_GAIN, 18'd0);
        write_reg(tpe_pkg::CFG_DIE_GAIN, 18'd0);
        write_reg(tpe_pkg::CFG_SENSE_GAIN, 18'd0);
        write_reg(tpe_pkg::CFG_RTH_MIN, 18'd0);
        write_reg(tpe_pkg::CFG_RTH_SPAN, 18'd0);
        for (int i = 0; i < 4; i++) send_tick(10'd1000, 16'hFFFF, 0);
        drain();

        // Random phases; the receiver keeps up in one of them.
        for (int phase = 0; phase < 6; phase++) begin
            random_config();
            rx_stall_on = (phase != 2);
            random_ticks(250);
            drain();
        end

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ===== thermal_plant_emulator_step.f =====
src/tpe_pkg.sv
src/tpe_ram.sv
src/tpe_front.sv
src/tpe_queue.sv
src/tpe_back.sv
src/thermal_plant_emulator_step.sv
sim/tpe_checker.sv
sim/tb.sv
